// ===== rtl/core/scl_pkg.sv =====
package scl_pkg;

    localparam int MAX_LINE   = 4096;
    localparam int IDX_W      = $clog2(MAX_LINE + 1);
    localparam int TOK_W      = 13;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // token kinds
    localparam logic [3:0] K_END        = 4'd0;
    localparam logic [3:0] K_NEWLINE    = 4'd1;
    localparam logic [3:0] K_DQ         = 4'd2;
    localparam logic [3:0] K_SQ         = 4'd3;
    localparam logic [3:0] K_WORD       = 4'd4;
    localparam logic [3:0] K_PIPE       = 4'd5;
    localparam logic [3:0] K_OUT        = 4'd6;
    localparam logic [3:0] K_IN         = 4'd7;
    localparam logic [3:0] K_ERR        = 4'd8;
    localparam logic [3:0] K_APPEND     = 4'd9;
    localparam logic [3:0] K_SEQ        = 4'd10;
    localparam logic [3:0] K_INCOMPLETE = 4'd11;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TWO   = 8'h32;

    typedef enum logic [1:0] {
        M_IDLE  = 2'd0,
        M_WORD  = 2'd1,
        M_QUOTE = 2'd2
    } t_mode;

    typedef struct packed {
        logic [3:0]       kind;
        logic [TOK_W-1:0] position;
        logic [TOK_W-1:0] length;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [3:0] f_classify(logic [1:0] cnt, logic [7:0] a, logic [7:0] b);
        logic [3:0] k;
        k = K_WORD;
        if (cnt == 2'd1) begin
            if (a == CH_PIPE)      k = K_PIPE;
            else if (a == CH_GT)   k = K_OUT;
            else if (a == CH_LT)   k = K_IN;
            else if (a == CH_SEMI) k = K_SEQ;
        end else if (cnt == 2'd2) begin
            if (a == CH_TWO && b == CH_GT)     k = K_ERR;
            else if (a == CH_GT && b == CH_GT) k = K_APPEND;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/scl_lexer.sv =====
module scl_lexer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_char_byte,
    output scl_pkg::t_push o_push
);

    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    scl_pkg::t_mode            r_mode, n_mode;
    logic                      r_dq, n_dq;
    logic [scl_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [scl_pkg::IDX_W-1:0] r_start, n_start;
    logic [7:0]                r_first, n_first;
    logic [7:0]                r_second, n_second;
    logic [1:0]                r_wcnt, n_wcnt;

    logic [scl_pkg::IDX_W-1:0] idx_adv;
    logic [scl_pkg::IDX_W:0]   pos_word;
    logic [scl_pkg::IDX_W:0]   len_word;
    logic [scl_pkg::IDX_W:0]   len_quote;
    logic [scl_pkg::TOK_W-1:0] pos_raw;
    logic [7:0]                c;
    logic                      is_sep;
    logic [7:0]                quote_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_take;
        end
        if (i_take) begin
            r_in_byte <= i_char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= scl_pkg::M_IDLE;
            r_dq     <= 1'b0;
            r_idx    <= '0;
            r_start  <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_wcnt   <= '0;
        end else begin
            r_mode   <= n_mode;
            r_dq     <= n_dq;
            r_idx    <= n_idx;
            r_start  <= n_start;
            r_first  <= n_first;
            r_second <= n_second;
            r_wcnt   <= n_wcnt;
        end
    end

    // index saturates at the line limit
    assign idx_adv   = (r_idx < scl_pkg::IDX_W'(scl_pkg::MAX_LINE)) ? r_idx + 1'b1 : r_idx;
    assign pos_word  = {1'b0, r_start} + 1'b1;
    assign len_word  = {1'b0, r_idx} - {1'b0, r_start};
    assign len_quote = {1'b0, r_idx} + 1'b1 - {1'b0, r_start};
    assign pos_raw   = scl_pkg::TOK_W'(r_idx);
    assign c         = r_in_byte;
    assign is_sep    = (c == scl_pkg::CH_SPACE) || (c == scl_pkg::CH_TAB);
    assign quote_ch  = r_dq ? scl_pkg::CH_DQ : scl_pkg::CH_SQ;

    always_comb begin
        n_mode   = r_mode;
        n_dq     = r_dq;
        n_idx    = r_idx;
        n_start  = r_start;
        n_first  = r_first;
        n_second = r_second;
        n_wcnt   = r_wcnt;
        o_push   = '0;

        if (r_in_valid) begin
            n_idx = idx_adv;
            unique case (r_mode)
                scl_pkg::M_WORD: begin
                    if (c == scl_pkg::CH_NUL || is_sep) begin
                        o_push.count         = 2'd1;
                        o_push.res0.kind     = scl_pkg::f_classify(r_wcnt, r_first, r_second);
                        o_push.res0.position = scl_pkg::TOK_W'(pos_word);
                        o_push.res0.length   = scl_pkg::TOK_W'(len_word);
                        o_push.res0.last     = (c != scl_pkg::CH_NUL);
                        n_mode               = scl_pkg::M_IDLE;
                    end else begin
                        if (r_wcnt == 2'd1) n_second = c;
                        if (r_wcnt != 2'd3) n_wcnt = r_wcnt + 1'b1;
                    end
                    if (c == scl_pkg::CH_NUL) begin
                        o_push.count         = 2'd2;
                        o_push.res1.kind     = scl_pkg::K_END;
                        o_push.res1.position = pos_raw;
                        o_push.res1.length   = '0;
                        o_push.res1.last     = 1'b1;
                    end
                end
                scl_pkg::M_QUOTE: begin
                    if (c == scl_pkg::CH_NUL) begin
                        o_push.count         = 2'd2;
                        o_push.res0.kind     = scl_pkg::K_INCOMPLETE;
                        o_push.res0.position = pos_raw;
                        o_push.res0.length   = '0;
                        o_push.res0.last     = 1'b0;
                        o_push.res1.kind     = scl_pkg::K_END;
                        o_push.res1.position = pos_raw;
                        o_push.res1.length   = '0;
                        o_push.res1.last     = 1'b1;
                    end else if (c == quote_ch) begin
                        o_push.count         = 2'd1;
                        o_push.res0.kind     = r_dq ? scl_pkg::K_DQ : scl_pkg::K_SQ;
                        o_push.res0.position = scl_pkg::TOK_W'(pos_word);
                        o_push.res0.length   = scl_pkg::TOK_W'(len_quote);
                        o_push.res0.last     = 1'b1;
                        n_mode               = scl_pkg::M_IDLE;
                    end
                end
                default: begin
                    if (c == scl_pkg::CH_NUL) begin
                        o_push.count         = 2'd1;
                        o_push.res0.kind     = scl_pkg::K_END;
                        o_push.res0.position = pos_raw;
                        o_push.res0.length   = '0;
                        o_push.res0.last     = 1'b1;
                    end else if (c == scl_pkg::CH_LF) begin
                        o_push.count         = 2'd1;
                        o_push.res0.kind     = scl_pkg::K_NEWLINE;
                        o_push.res0.position = pos_raw;
                        o_push.res0.length   = scl_pkg::TOK_W'(1);
                        o_push.res0.last     = 1'b1;
                    end else if (c == scl_pkg::CH_DQ || c == scl_pkg::CH_SQ) begin
                        n_mode  = scl_pkg::M_QUOTE;
                        n_dq    = (c == scl_pkg::CH_DQ);
                        n_start = r_idx;
                    end else if (!is_sep) begin
                        n_mode   = scl_pkg::M_WORD;
                        n_start  = r_idx;
                        n_first  = c;
                        n_second = '0;
                        n_wcnt   = 2'd1;
                    end
                end
            endcase

            // line end returns everything to the reset state
            if (c == scl_pkg::CH_NUL) begin
                n_mode   = scl_pkg::M_IDLE;
                n_dq     = 1'b0;
                n_idx    = '0;
                n_start  = '0;
                n_first  = '0;
                n_second = '0;
                n_wcnt   = '0;
            end
        end
    end

endmodule

// ===== rtl/core/scl_fifo.sv =====
module scl_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scl_pkg::t_push            i_push,
    input  logic                      i_pop,
    output logic                      o_valid,
    output scl_pkg::t_result          o_head,
    output logic [scl_pkg::CNT_W-1:0] o_count
);

    scl_pkg::t_result          r_mem [scl_pkg::FIFO_DEPTH];
    logic [scl_pkg::PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [scl_pkg::CNT_W-1:0] r_count;
    logic [scl_pkg::PTR_W-1:0] wr_ptr1;
    logic                      pop_ok;

    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign pop_ok  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + scl_pkg::PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + scl_pkg::PTR_W'(pop_ok);
            r_count  <= r_count + scl_pkg::CNT_W'(i_push.count) - scl_pkg::CNT_W'(pop_ok);
        end
        if (i_push.count != 2'd0) r_mem[r_wr_ptr] <= i_push.res0;
        if (i_push.count == 2'd2) r_mem[wr_ptr1]  <= i_push.res1;
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== rtl/core/shell_command_line_tokenizer.sv =====
// Byte-serial shell command line lexer. Feed one byte of the line per transfer on
// i_char_byte; a zero byte ends the line and restarts the position count. Each token
// comes out as kind, position and length (no text is copied): quoted words, bare words
// classed as pipe, redirects, append, sequence or plain word, lone newlines, an
// incomplete marker for an unclosed quote, and an end marker. o_last_of_run flags the
// final result caused by one input byte. The block takes one byte per cycle while o_stall
// is low. A result passes the input register and then, with the lexer state update, the
// four-entry result queue before it reaches the output. A byte that ends the line inside
// a word or quote yields two results, and since the queue drains one result per cycle
// while i_stall is low, such a byte needs two output transfers. No clearing pass after
// reset.
module shell_command_line_tokenizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input byte channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_char_byte,
    // token result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [3:0]                  o_token_kind,
    output logic [scl_pkg::TOK_W-1:0]   o_token_position,
    output logic [scl_pkg::TOK_W-1:0]   o_token_length,
    output logic                        o_last_of_run
);

    scl_pkg::t_push            push;
    scl_pkg::t_result          head;
    logic [scl_pkg::CNT_W-1:0] count;
    logic [scl_pkg::CNT_W:0]   fill;
    logic                      take;

    // the byte sitting in the lexer input register always gets room in the queue;
    // a new byte is only taken if the queue can still absorb two more results
    // after this cycle's push, ignoring any pop so stall never waits on i_stall
    assign fill    = {1'b0, count} + (scl_pkg::CNT_W + 1)'(push.count);
    assign o_stall = fill > (scl_pkg::CNT_W + 1)'(scl_pkg::FIFO_DEPTH - 2);
    assign take    = i_valid && !o_stall;

    // lexer: input register plus token state, emits up to two results per byte
    scl_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_byte (i_char_byte),
        .o_push      (push)
    );

    // result queue, decouples output stalls from byte intake
    scl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_head  (head),
        .o_count (count)
    );

    assign o_token_kind     = head.kind;
    assign o_token_position = head.position;
    assign o_token_length   = head.length;
    assign o_last_of_run    = head.last;

endmodule

// ===== rtl/core/scl_checker.sv =====
module scl_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [3:0]                o_token_kind,
    input logic [scl_pkg::TOK_W-1:0] o_token_position,
    input logic [scl_pkg::TOK_W-1:0] o_token_length,
    input logic                      o_last_of_run
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_token_kind)
            && $stable(o_token_position) && $stable(o_token_length)
            && $stable(o_last_of_run)))
        else $error("stalled result changed");

    // end of line is always the final result of its byte and has no length
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == scl_pkg::K_END) |-> (o_last_of_run && o_token_length == '0))
        else $error("bad end token");

    // incomplete is always followed by end
    a_incomplete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_token_kind == scl_pkg::K_INCOMPLETE) |=>
            (!o_valid || o_token_kind == scl_pkg::K_END))
        else $error("incomplete not followed by end");

    // a result that is not last of its byte is never end, newline or a quoted word
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (o_token_kind != scl_pkg::K_END
            && o_token_kind != scl_pkg::K_NEWLINE && o_token_kind != scl_pkg::K_DQ
            && o_token_kind != scl_pkg::K_SQ))
        else $error("unexpected first-of-two result");

endmodule

bind shell_command_line_tokenizer scl_checker u_scl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_token_kind     (o_token_kind),
    .o_token_position (o_token_position),
    .o_token_length   (o_token_length),
    .o_last_of_run    (o_last_of_run)
);
